/* src/wpm_pkg.sv */
// Shared types and constants for the wildcard pattern matcher.
// No dependencies; every other file of the block imports this package.
package wpm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    localparam logic [CHAR_W-1:0] CH_ANY = 8'h3F;  // '?'
    localparam logic [CHAR_W-1:0] CH_RUN = 8'h2A;  // '*'

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic              last;   // final text byte of a string
        logic              emits;  // command produces a result transaction
    } cmd_t;

endpackage

/* src/wpm_front.sv */
// Front end: takes input transactions and decodes them into queue commands.
// Depends on wpm_pkg.
module wpm_front (
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wpm_pkg::OP_W-1:0]    s_opcode,
    input  logic [wpm_pkg::CHAR_W-1:0]  s_char_in,
    input  logic                        s_last_char,
    input  logic                        q_full,
    output logic                        push,
    output wpm_pkg::cmd_t               cmd
);
    import wpm_pkg::*;

    logic is_text;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;
    assign is_text = (s_opcode == OP_TEXT);

    always_comb begin
        cmd.op    = s_opcode;
        cmd.ch    = s_char_in;
        // last_char means nothing outside text bytes
        cmd.last  = is_text && s_last_char;
        cmd.emits = (s_opcode == OP_QUERY) || (is_text && s_last_char);
    end

endmodule

/* src/wpm_queue.sv */
// Short command queue between the front and back ends.
// Depends on wpm_pkg for the command type and depth.
module wpm_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  wpm_pkg::cmd_t push_cmd,
    output logic          full,
    output logic          q_valid,
    input  logic          pop,
    output wpm_pkg::cmd_t head_cmd
);
    import wpm_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* src/wpm_back.sv */
// Back end: pattern cells, match row update and the result register.
// Depends on wpm_pkg.
module wpm_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  wpm_pkg::cmd_t head_cmd,
    output logic          pop,
    output logic          m_valid,
    input  logic          m_ready,
    output logic          m_matched,
    output logic          m_pattern_overflow
);
    import wpm_pkg::*;

    logic [CHAR_W-1:0]      pat_reg [MAX_PATTERN];
    logic [LEN_W-1:0]       len_reg;
    logic [MAX_PATTERN-1:0] row_reg;
    logic [MAX_PATTERN-1:0] row_next;
    logic                   first_reg;
    logic                   ovf_reg;
    logic                   m_valid_reg;
    logic                   m_matched_reg;
    logic                   m_ovf_reg;
    logic                   text_match;
    logic [IDX_W-1:0]       last_idx;
    logic [IDX_W-1:0]       wr_idx;

    assign pop      = q_valid && (!m_valid_reg || m_ready);
    assign last_idx = IDX_W'(len_reg - 1'b1);
    assign wr_idx   = len_reg[IDX_W-1:0];

    // One cell per pattern position; a star cell passes its left neighbor along.
    always_comb begin
        logic all_star;
        logic live;
        logic hit;
        logic star;
        all_star = 1'b1;
        row_next = '0;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            live = (LEN_W'(j) < len_reg);
            hit  = live && ((pat_reg[j] == CH_ANY) || (pat_reg[j] == head_cmd.ch));
            star = live && (pat_reg[j] == CH_RUN);
            if (hit) begin
                if (j == 0) begin
                    row_next[j] = first_reg;
                end else begin
                    row_next[j] = first_reg ? all_star : row_reg[j-1];
                end
            end else if (star) begin
                if (j == 0) begin
                    row_next[j] = 1'b1;
                end else if (first_reg) begin
                    row_next[j] = row_next[j-1];
                end else begin
                    row_next[j] = row_next[j-1] || row_reg[j] || row_reg[j-1];
                end
            end
            if (pat_reg[j] != CH_RUN) begin
                all_star = 1'b0;
            end
        end
    end

    assign text_match = (len_reg != '0) && row_next[last_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            row_reg   <= '0;
            first_reg <= 1'b1;
            ovf_reg   <= 1'b0;
        end else if (pop) begin
            unique case (head_cmd.op)
                OP_CLEAR: begin
                    len_reg   <= '0;
                    ovf_reg   <= 1'b0;
                    row_reg   <= '0;
                    first_reg <= 1'b1;
                end
                OP_APPEND: begin
                    if (len_reg < LEN_W'(MAX_PATTERN)) begin
                        len_reg <= len_reg + 1'b1;
                    end else begin
                        ovf_reg <= 1'b1;
                    end
                    row_reg   <= '0;
                    first_reg <= 1'b1;
                end
                OP_TEXT: begin
                    if (head_cmd.last) begin
                        row_reg   <= '0;
                        first_reg <= 1'b1;
                    end else begin
                        row_reg   <= row_next;
                        first_reg <= 1'b0;
                    end
                end
                default: begin
                    row_reg   <= '0;
                    first_reg <= 1'b1;
                end
            endcase
        end
    end

    // Pattern bytes; entries past the length are never used.
    always_ff @(posedge aclk) begin
        if (pop && (head_cmd.op == OP_APPEND) && (len_reg < LEN_W'(MAX_PATTERN))) begin
            pat_reg[wr_idx] <= head_cmd.ch;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && head_cmd.emits) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_cmd.emits) begin
            m_matched_reg <= (head_cmd.op == OP_QUERY) ? (len_reg == '0) : text_match;
            m_ovf_reg     <= ovf_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_matched          = m_matched_reg;
    assign m_pattern_overflow = m_ovf_reg;

endmodule

/* src/wildcard_pattern_matcher.sv */
// Wildcard pattern matcher: input channel, command queue and match engine.
// Depends on wpm_pkg, wpm_front, wpm_queue and wpm_back.
//
// Usage:
//   The s_ channel carries one command per transaction: clear the pattern,
//   append a pattern byte, stream a text byte (s_last_char marks the end of
//   a string) or query an empty text. '?' matches any byte, '*' any run.
//   The m_ channel returns one transaction per finished string or empty
//   query: m_matched and the sticky m_pattern_overflow flag.
//   Result path: a result goes through a queue entry and the output
//   register; the entry is popped once it heads the queue and the output
//   register is free, and the match row update lands straight in it.
//   Throughput: one transaction per cycle unless m_ready stalls; every
//   pattern cell updates in parallel each cycle, star propagation along the
//   row sets the path. A stalled m_ready holds the result; the two-entry queue
//   keeps taking input until it fills, then s_ready drops.
//   Reset empties the queue and the output, clears the pattern length,
//   match row and overflow flag. Pattern bytes need no reset.
module wildcard_pattern_matcher (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [wpm_pkg::OP_W-1:0]    s_opcode,
    input  logic [wpm_pkg::CHAR_W-1:0]  s_char_in,
    input  logic                        s_last_char,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_matched,
    output logic                        m_pattern_overflow
);
    import wpm_pkg::*;

    logic q_full;
    logic push;
    logic q_valid;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;

    wpm_front u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_char_in   (s_char_in),
        .s_last_char (s_last_char),
        .q_full      (q_full),
        .push        (push),
        .cmd         (push_cmd)
    );

    wpm_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .q_valid  (q_valid),
        .pop      (pop),
        .head_cmd (head_cmd)
    );

    wpm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .head_cmd           (head_cmd),
        .pop                (pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for wildcard_pattern_matcher: directed and random command streams,
// a glob-match predictor and an in-order scoreboard on the result channel.
// Depends on wpm_pkg and the wildcard_pattern_matcher RTL.
module testbench;
    import wpm_pkg::*;

    localparam int NUM_ITEMS  = 1450;
    localparam int CALM_TAIL  = 150;
    localparam int LONG_HOLD  = 200;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_SHOWN  = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic              last;
    } cmd_item_t;

    typedef struct packed {
        logic matched;
        logic overflow;
    } verdict_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    logic [OP_W-1:0]   s_opcode    = OP_CLEAR;
    logic [CHAR_W-1:0] s_char_in   = '0;
    logic              s_last_char = 1'b0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    logic              m_matched;
    logic              m_pattern_overflow;

    wildcard_pattern_matcher u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_char_in          (s_char_in),
        .s_last_char        (s_last_char),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_matched          (m_matched),
        .m_pattern_overflow (m_pattern_overflow)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    cmd_item_t cmd_q[$];
    verdict_t  verdict_q[$];

    int n_sent     = 0;
    int n_taken    = 0;
    int n_results  = 0;
    int n_hits     = 0;
    int n_ovf      = 0;
    int n_errors   = 0;
    int n_sessions = 0;

    // Predictor state: pattern bytes, length, match row and flags
    logic [CHAR_W-1:0]      pat_mem [MAX_PATTERN];
    int                     pat_len    = 0;
    logic [MAX_PATTERN-1:0] row_bits   = '0;
    bit                     first_byte = 1'b1;
    bit                     ovf_flag   = 1'b0;

    function automatic bit predict_match(input cmd_item_t c, output verdict_t v);
        logic [MAX_PATTERN-1:0] nxt;
        logic [CHAR_W-1:0]      p;
        bit                     all_star;
        bit                     hit;
        bit                     emits;
        emits = 1'b0;
        v     = '0;
        case (c.op)
            OP_CLEAR: begin
                pat_len  = 0;
                ovf_flag = 1'b0;
            end
            OP_APPEND: begin
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = c.ch;
                    pat_len++;
                end else begin
                    ovf_flag = 1'b1;
                end
            end
            OP_TEXT: begin
                nxt      = '0;
                all_star = 1'b1;
                for (int j = 0; j < pat_len; j++) begin
                    p = pat_mem[j];
                    // equality first: a text star facing a pattern star is literal
                    if (p == CH_ANY || p == c.ch) begin
                        if (first_byte)
                            hit = (j == 0) ? 1'b1 : all_star;
                        else
                            hit = (j == 0) ? 1'b0 : row_bits[j-1];
                    end else if (p == CH_RUN) begin
                        if (j == 0)
                            hit = 1'b1;
                        else if (first_byte)
                            hit = nxt[j-1];
                        else
                            hit = nxt[j-1] || row_bits[j] || row_bits[j-1];
                    end else begin
                        hit = 1'b0;
                    end
                    nxt[j] = hit;
                    if (p != CH_RUN)
                        all_star = 1'b0;
                end
                row_bits   = nxt;
                first_byte = 1'b0;
                if (c.last) begin
                    v.matched  = (pat_len > 0) && nxt[pat_len-1];
                    v.overflow = ovf_flag;
                    emits      = 1'b1;
                end
            end
            default: begin
                v.matched  = (pat_len == 0);
                v.overflow = ovf_flag;
                emits      = 1'b1;
            end
        endcase
        // anything but a mid-string text byte restarts the text
        if (c.op != OP_TEXT || c.last) begin
            row_bits   = '0;
            first_byte = 1'b1;
        end
        return emits;
    endfunction

    task automatic report_mismatch(input string what, input verdict_t want, input verdict_t got);
        n_errors++;
        if (n_errors <= MAX_SHOWN)
            $display("%0t: %s: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                     $time, what, want.matched, want.overflow, got.matched, got.overflow);
    endtask

    // Predict on each input transaction, check each result transaction
    always @(posedge aclk) begin : scoreboard
        cmd_item_t c;
        verdict_t  v;
        verdict_t  got;
        verdict_t  want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c.op   = s_opcode;
                c.ch   = s_char_in;
                c.last = s_last_char;
                n_taken++;
                if (predict_match(c, v))
                    verdict_q.push_back(v);
            end
            if (m_valid && m_ready) begin
                got.matched  = m_matched;
                got.overflow = m_pattern_overflow;
                n_results++;
                if (m_matched)
                    n_hits++;
                if (m_pattern_overflow)
                    n_ovf++;
                if (verdict_q.size() == 0) begin
                    report_mismatch("result with nothing pending", '0, got);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.matched !== want.matched || got.overflow !== want.overflow)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Sender: hold an offered transaction until taken, idle in short bursts
    int send_gap = 0;

    always @(negedge aclk) begin : driver
        cmd_item_t c;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && n_taken < n_sent)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (cmd_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (cmd_q.size() > CALM_TAIL && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(0, 5);
                s_valid <= 1'b0;
            end else begin
                c = cmd_q.pop_front();
                s_opcode    <= c.op;
                s_char_in   <= c.ch;
                s_last_char <= c.last;
                s_valid     <= 1'b1;
                n_sent++;
            end
        end
    end

    // Receiver: short random stalls plus one long hold-off to fill the block
    int hold_left      = 0;
    bit long_hold_done = 1'b0;

    always @(negedge aclk) begin : receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && n_taken >= 300) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (cmd_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 5);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: give up after too many cycles without any transaction
    int idle_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[wildcard_pattern_matcher] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic [CHAR_W-1:0] ch,
                           input logic last);
        cmd_item_t c;
        c.op   = op;
        c.ch   = ch;
        c.last = last;
        cmd_q.push_back(c);
    endtask

    // Send a string as text bytes; an empty one becomes an empty-text query
    task automatic add_bytes(input logic [CHAR_W-1:0] txt[$]);
        if (txt.size() == 0)
            add_cmd(OP_QUERY, CHAR_W'($urandom), 1'($urandom));
        for (int i = 0; i < txt.size(); i++)
            add_cmd(OP_TEXT, txt[i], i == txt.size() - 1);
    endtask

    task automatic add_text(input string s);
        logic [CHAR_W-1:0] txt[$];
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        add_bytes(txt);
    endtask

    task automatic add_pattern(input string s);
        add_cmd(OP_CLEAR, 8'h00, 1'b0);
        for (int i = 0; i < s.len(); i++)
            add_cmd(OP_APPEND, s[i], 1'b0);
    endtask

    function automatic logic [CHAR_W-1:0] letter();
        return 8'h61 + CHAR_W'($urandom_range(0, 2));
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_char();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 7)
            return CH_RUN;
        if (roll < 11)
            return CH_ANY;
        if (roll < 18)
            return letter();
        return CHAR_W'($urandom);
    endfunction

    function automatic logic [CHAR_W-1:0] text_char();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 3)
            return CH_RUN;
        if (roll < 5)
            return CH_ANY;
        if (roll < 17)
            return letter();
        return CHAR_W'($urandom);
    endfunction

    // Text built to fit the pattern, sometimes spoiled by one edit
    task automatic add_fitting_text(input logic [CHAR_W-1:0] pat[$]);
        logic [CHAR_W-1:0] txt[$];
        int                runs;
        for (int i = 0; i < pat.size(); i++) begin
            if (pat[i] == CH_RUN) begin
                runs = $urandom_range(0, 3);
                repeat (runs) txt.push_back(text_char());
            end else if (pat[i] == CH_ANY) begin
                txt.push_back(text_char());
            end else begin
                txt.push_back(pat[i]);
            end
        end
        if (txt.size() > 0 && $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1) == 0)
                txt[$urandom_range(0, txt.size() - 1)] = text_char();
            else
                void'(txt.pop_back());
        end
        add_bytes(txt);
    endtask

    task automatic add_loose_text();
        logic [CHAR_W-1:0] txt[$];
        int                len;
        len = $urandom_range(0, 6);
        repeat (len) txt.push_back(text_char());
        add_bytes(txt);
    endtask

    // Clear, load a pattern, then run a few strings against it
    task automatic add_session();
        logic [CHAR_W-1:0] pat[$];
        int                len;
        int                roll;
        int                n_texts;
        roll = $urandom_range(0, 99);
        if (roll < 80)
            len = $urandom_range(0, 6);
        else if (roll < 93)
            len = $urandom_range(7, 31);
        else
            len = $urandom_range(32, 36);
        add_cmd(OP_CLEAR, CHAR_W'($urandom), 1'($urandom));
        for (int i = 0; i < len; i++) begin
            pat.push_back(pattern_char());
            add_cmd(OP_APPEND, pat[i], 1'($urandom));
        end
        n_texts = $urandom_range(1, 4);
        for (int t = 0; t < n_texts; t++) begin
            if ($urandom_range(0, 2) != 0)
                add_fitting_text(pat);
            else
                add_loose_text();
        end
        n_sessions++;
    endtask

    initial begin : stimulus
        int burst;
        // Directed part
        add_cmd(OP_QUERY, 8'h00, 1'b1);   // empty pattern, empty text
        add_text("a");                    // empty pattern never matches text
        add_pattern("a?c");
        add_text("abc");
        add_text("abd");
        add_pattern("**a");
        add_text("a");                    // leading stars match an empty prefix
        add_pattern("*");
        add_text("*");
        add_text("x*");                   // later text star meets the leading star literally
        add_cmd(OP_TEXT, "a", 1'b0);
        add_cmd(OP_APPEND, 8'hFF, 1'b1);  // abandons the string in progress
        add_cmd(OP_TEXT, 8'hFF, 1'b1);
        add_cmd(OP_TEXT, "a", 1'b0);
        add_cmd(OP_QUERY, 8'h00, 1'b0);   // query mid-string on a non-empty pattern
        add_cmd(OP_CLEAR, 8'hFF, 1'b1);
        add_cmd(OP_APPEND, 8'h00, 1'b0);
        add_cmd(OP_TEXT, 8'h00, 1'b1);
        add_cmd(OP_TEXT, 8'hFF, 1'b1);

        // Random part: mostly well-formed sessions, some raw noise
        while (cmd_q.size() < NUM_ITEMS) begin
            if ($urandom_range(0, 99) < 88) begin
                add_session();
            end else begin
                burst = $urandom_range(1, 5);
                repeat (burst) add_cmd(OP_W'($urandom_range(0, 3)), CHAR_W'($urandom),
                                       1'($urandom));
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_q.size() != 0 || s_valid || verdict_q.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d commands in %0d pattern sessions, long receiver hold-off included.",
                 n_taken, n_sessions);
        $display("Checked %0d results: %0d matched, %0d with overflow set, %0d mismatches.",
                 n_results, n_hits, n_ovf, n_errors);
        if (n_errors == 0 && verdict_q.size() == 0) begin
            $display("[wildcard_pattern_matcher] OK");
        end else begin
            $display("[wildcard_pattern_matcher] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/wpm_pkg.sv
src/wpm_front.sv
src/wpm_queue.sv
src/wpm_back.sv
src/wildcard_pattern_matcher.sv
sim/testbench.sv
